// ----- src/i8cr_pkg.sv -----
// ============================================================================
// i8cr_pkg: shared definitions for the int8 concatenation requantizer
// Holds the fixed field widths, stream packing widths and the configuration
// register codes used by the requantizer and its port checker.
// ============================================================================
`default_nettype none

package i8cr_pkg;

    // Fixed field widths of the sample and result items.
    localparam int SAMPLE_WIDTH    = 8;
    localparam int RATIO_WIDTH     = 24;
    localparam int BATCH_WIDTH     = 8;
    localparam int INDEX_WIDTH     = 33;

    // Stream packing: out_value in the low byte, out_index above it, zero filled.
    localparam int IN_TDATA_WIDTH  = 8;
    localparam int OUT_TDATA_WIDTH = 48;

    // Configuration register index codes.
    localparam int CFG_INDEX_WIDTH = 3;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_FIRST_RATIO   = 3'd0,
        CFG_SECOND_RATIO  = 3'd1,
        CFG_CLAMP_LOW     = 3'd2,
        CFG_CLAMP_HIGH    = 3'd3,
        CFG_FIRST_LENGTH  = 3'd4,
        CFG_SECOND_LENGTH = 3'd5,
        CFG_BATCH_COUNT   = 3'd6
    } t_cfg_reg;

    // Reset values of the configuration registers that do not depend on parameters.
    localparam logic [RATIO_WIDTH-1:0]  RATIO_RESET      = 24'd65536;
    localparam logic [SAMPLE_WIDTH-1:0] CLAMP_LOW_RESET  = 8'h80;
    localparam logic [SAMPLE_WIDTH-1:0] CLAMP_HIGH_RESET = 8'h7F;
    localparam logic [BATCH_WIDTH-1:0]  BATCH_RESET      = 8'd1;

endpackage : i8cr_pkg

`default_nettype wire

// ----- src/int8_concat_requantizer.sv -----
// ============================================================================
// int8_concat_requantizer: requantizes a concatenated int8 sample stream
// Tracks segment, position and batch of each incoming sample, scales it by
// its segment's fixed-point ratio, rounds half away from zero, clamps it to
// the activation limits and emits it with its linear output index.
// ============================================================================
// Each sample is registered in the index stage, then its result in the result stage.
// Throughput: one sample per cycle unless the output stalls; the index stage
//   and the multiply, round and clamp stage each hold one sample.
// Reset (synchronous, active low) empties both stages, clears the segment,
//   position, batch and index counters and loads the register reset values.
`default_nettype none

module int8_concat_requantizer #(
    parameter int RATIO_FRACTION_BITS = 16,
    parameter int LENGTH_WIDTH        = 24,
    localparam int CfgDataWidth = (LENGTH_WIDTH > i8cr_pkg::RATIO_WIDTH) ?
                                  LENGTH_WIDTH : i8cr_pkg::RATIO_WIDTH
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,

    // Configuration write port.
    input  wire logic                                   i_cfg_wr_en,
    input  wire logic [i8cr_pkg::CFG_INDEX_WIDTH-1:0]   i_cfg_index,
    input  wire logic [CfgDataWidth-1:0]                i_cfg_data,

    // Sample stream in.
    input  wire logic                                   s_axis_tvalid,
    output      logic                                   s_axis_tready,
    input  wire logic [i8cr_pkg::IN_TDATA_WIDTH-1:0]    s_axis_tdata,  // [7:0] sample_value

    // Result stream out.
    output      logic                                   m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    // [7:0] out_value, [40:8] out_index, [47:41] zero
    output      logic [i8cr_pkg::OUT_TDATA_WIDTH-1:0]   m_axis_tdata,
    output      logic                                   m_axis_tuser,  // [0] from_second
    output      logic                                   m_axis_tlast   // is_last
);

    localparam int SW       = i8cr_pkg::SAMPLE_WIDTH;
    localparam int RW       = i8cr_pkg::RATIO_WIDTH;
    localparam int BW       = i8cr_pkg::BATCH_WIDTH;
    localparam int IW       = i8cr_pkg::INDEX_WIDTH;
    localparam int PROD_W   = SW + RW;
    localparam int QUOT_W   = PROD_W + 1 - RATIO_FRACTION_BITS;
    localparam int CLAMP_W  = SW + 2;
    localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(1) << (RATIO_FRACTION_BITS - 1);

    // Configuration registers.
    logic [RW-1:0]           r_first_ratio;
    logic [RW-1:0]           r_second_ratio;
    logic [SW-1:0]           r_clamp_low;
    logic [SW-1:0]           r_clamp_high;
    logic [LENGTH_WIDTH-1:0] r_first_length;
    logic [LENGTH_WIDTH-1:0] r_second_length;
    logic [BW-1:0]           r_batch_count;

    // Position counters.
    logic                    r_segment;
    logic [LENGTH_WIDTH-1:0] r_position;
    logic [BW-1:0]           r_batch;
    logic [IW-1:0]           r_next_index;

    // Index stage.
    logic                    r_s1_valid;
    logic [SW-1:0]           r_s1_sample;
    logic                    r_s1_second;
    logic                    r_s1_last;
    logic [IW-1:0]           r_s1_index;

    // Result stage.
    logic                    r_out_valid;
    logic [SW-1:0]           r_out_value;
    logic [IW-1:0]           r_out_index;
    logic                    r_out_second;
    logic                    r_out_last;

    logic                    out_advance;
    logic                    s1_advance;
    logic                    in_transfer;

    logic [LENGTH_WIDTH-1:0] cur_length;
    logic                    seg_end;
    logic                    batch_end;
    logic                    item_last;

    logic [RW-1:0]           s1_ratio;
    logic [SW:0]             s1_neg;
    logic [SW-1:0]           s1_mag;
    logic [PROD_W-1:0]       s1_prod;
    logic [PROD_W:0]         s1_rounded;
    logic [QUOT_W-1:0]       s1_quot;
    logic [SW-1:0]           s1_sat;
    logic signed [CLAMP_W-1:0] s1_signed;
    logic signed [CLAMP_W-1:0] s1_low;
    logic signed [CLAMP_W-1:0] s1_high;
    logic signed [CLAMP_W-1:0] s1_raised;
    logic signed [CLAMP_W-1:0] n_out_value;

    // Handshake: each stage moves when the stage after it can take its sample.
    assign out_advance   = !r_out_valid || m_axis_tready;
    assign s1_advance    = !r_s1_valid || out_advance;
    assign s_axis_tready = s1_advance;
    assign in_transfer   = s_axis_tvalid && s1_advance;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_ratio   <= i8cr_pkg::RATIO_RESET;
            r_second_ratio  <= i8cr_pkg::RATIO_RESET;
            r_clamp_low     <= i8cr_pkg::CLAMP_LOW_RESET;
            r_clamp_high    <= i8cr_pkg::CLAMP_HIGH_RESET;
            r_first_length  <= LENGTH_WIDTH'(1);
            r_second_length <= LENGTH_WIDTH'(1);
            r_batch_count   <= i8cr_pkg::BATCH_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                i8cr_pkg::CFG_FIRST_RATIO:   r_first_ratio   <= i_cfg_data[RW-1:0];
                i8cr_pkg::CFG_SECOND_RATIO:  r_second_ratio  <= i_cfg_data[RW-1:0];
                i8cr_pkg::CFG_CLAMP_LOW:     r_clamp_low     <= i_cfg_data[SW-1:0];
                i8cr_pkg::CFG_CLAMP_HIGH:    r_clamp_high    <= i_cfg_data[SW-1:0];
                i8cr_pkg::CFG_FIRST_LENGTH:  r_first_length  <= i_cfg_data[LENGTH_WIDTH-1:0];
                i8cr_pkg::CFG_SECOND_LENGTH: r_second_length <= i_cfg_data[LENGTH_WIDTH-1:0];
                i8cr_pkg::CFG_BATCH_COUNT:   r_batch_count   <= i_cfg_data[BW-1:0];
                default: ;
            endcase
        end
    end

    // End-of-segment, end-of-batch and end-of-output detection.
    // A zero length or batch count ends at the first sample.
    always_comb begin
        cur_length = r_segment ? r_second_length : r_first_length;
        seg_end    = ({1'b0, r_position} + (LENGTH_WIDTH + 1)'(1)) >= {1'b0, cur_length};
        batch_end  = ({1'b0, r_batch} + (BW + 1)'(1)) >= {1'b0, r_batch_count};
        item_last  = r_segment && seg_end && batch_end;
    end

    // Counters advance on each input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_segment    <= 1'b0;
            r_position   <= '0;
            r_batch      <= '0;
            r_next_index <= '0;
        end else if (in_transfer) begin
            if (item_last) begin
                r_segment    <= 1'b0;
                r_position   <= '0;
                r_batch      <= '0;
                r_next_index <= '0;
            end else begin
                r_next_index <= r_next_index + IW'(1);
                if (seg_end) begin
                    r_position <= '0;
                    r_segment  <= !r_segment;
                    if (r_segment) begin
                        r_batch <= r_batch + BW'(1);
                    end
                end else begin
                    r_position <= r_position + LENGTH_WIDTH'(1);
                end
            end
        end
    end

    // Index stage: capture the sample with its place in the output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_advance) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_transfer) begin
            r_s1_sample <= s_axis_tdata[SW-1:0];
            r_s1_second <= r_segment;
            r_s1_last   <= item_last;
            r_s1_index  <= r_next_index;
        end
    end

    // Multiply the magnitude by the ratio, round half away from zero,
    // saturate the magnitude, restore the sign and clamp.
    always_comb begin
        s1_ratio   = r_s1_second ? r_second_ratio : r_first_ratio;
        s1_neg     = (SW + 1)'(0) - {r_s1_sample[SW-1], r_s1_sample};
        s1_mag     = r_s1_sample[SW-1] ? s1_neg[SW-1:0] : r_s1_sample;
        s1_prod    = PROD_W'(s1_mag) * PROD_W'(s1_ratio);
        s1_rounded = {1'b0, s1_prod} + ROUND_HALF;
        s1_quot    = s1_rounded[PROD_W:RATIO_FRACTION_BITS];
        // Any magnitude above the int8 range clamps the same way as the largest byte.
        s1_sat     = (|s1_quot[QUOT_W-1:SW]) ? {SW{1'b1}} : s1_quot[SW-1:0];
        s1_signed  = r_s1_sample[SW-1] ? -$signed({2'b00, s1_sat}) : $signed({2'b00, s1_sat});
        s1_low     = CLAMP_W'($signed(r_clamp_low));
        s1_high    = CLAMP_W'($signed(r_clamp_high));
        s1_raised  = (s1_signed < s1_low) ? s1_low : s1_signed;
        n_out_value = (s1_raised > s1_high) ? s1_high : s1_raised;
    end

    // Result stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_advance && r_s1_valid) begin
            r_out_value  <= n_out_value[SW-1:0];
            r_out_index  <= r_s1_index;
            r_out_second <= r_s1_second;
            r_out_last   <= r_s1_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(i8cr_pkg::OUT_TDATA_WIDTH - IW - SW)'(0), r_out_index, r_out_value};
    assign m_axis_tuser  = r_out_second;
    assign m_axis_tlast  = r_out_last;

endmodule : int8_concat_requantizer

`default_nettype wire

// ----- src/i8cr_checker.sv -----
// ============================================================================
// i8cr_checker: port-level checks for the int8 concatenation requantizer
// Watches the configuration and stream ports and checks index sequencing,
// clamping, flag consistency and the result stall behavior.
// ============================================================================
`default_nettype none

module i8cr_checker #(
    parameter int LENGTH_WIDTH = 24,
    localparam int CfgDataWidth = (LENGTH_WIDTH > i8cr_pkg::RATIO_WIDTH) ?
                                  LENGTH_WIDTH : i8cr_pkg::RATIO_WIDTH
) (
    input wire logic                                  i_clk,
    input wire logic                                  i_rst_n,
    input wire logic                                  i_cfg_wr_en,
    input wire logic [i8cr_pkg::CFG_INDEX_WIDTH-1:0]  i_cfg_index,
    input wire logic [CfgDataWidth-1:0]               i_cfg_data,
    input wire logic                                  s_axis_tvalid,
    input wire logic                                  s_axis_tready,
    input wire logic [i8cr_pkg::IN_TDATA_WIDTH-1:0]   s_axis_tdata,
    input wire logic                                  m_axis_tvalid,
    input wire logic                                  m_axis_tready,
    input wire logic [i8cr_pkg::OUT_TDATA_WIDTH-1:0]  m_axis_tdata,
    input wire logic                                  m_axis_tuser,
    input wire logic                                  m_axis_tlast
);

    localparam int SW = i8cr_pkg::SAMPLE_WIDTH;
    localparam int IW = i8cr_pkg::INDEX_WIDTH;

    logic [IW-1:0] r_expect_index;
    logic [SW-1:0] r_clamp_high;
    logic [IW-1:0] out_index;
    logic          out_transfer;

    assign out_index    = m_axis_tdata[SW+IW-1:SW];
    assign out_transfer = m_axis_tvalid && m_axis_tready;

    // Expected index of the next result: restarts at zero after the last one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_index <= '0;
        end else if (out_transfer) begin
            r_expect_index <= m_axis_tlast ? '0 : out_index + IW'(1);
        end
    end

    // Shadow of the upper activation limit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clamp_high <= i8cr_pkg::CLAMP_HIGH_RESET;
        end else if (i_cfg_wr_en && (i_cfg_index == i8cr_pkg::CFG_CLAMP_HIGH)) begin
            r_clamp_high <= i_cfg_data[SW-1:0];
        end
    end

    // Output indexes run consecutively within one output tensor.
    a_index_sequence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (out_index == r_expect_index))
        else $error("result index out of sequence");

    // No result exceeds the upper activation limit.
    a_clamp_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[SW-1:0]) <= $signed(r_clamp_high)))
        else $error("result above the upper activation limit");

    // The final sample of an output always belongs to the second segment.
    a_last_in_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
        else $error("last sample flagged outside the second segment");

    // With the result register empty, the input side takes a sample.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while no result is pending");

    // A stalled result holds until its transfer.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
             && $stable(m_axis_tlast)))
        else $error("stalled result changed before its transfer");

endmodule : i8cr_checker

bind int8_concat_requantizer i8cr_checker #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
) u_i8cr_checker (.*);

`default_nettype wire

// ----- bench/int8_concat_requantizer_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// int8_concat_requantizer_tb: self-checking bench for the concat requantizer
// Streams signed samples through the block under several register settings.
// A scoreboard predicts the value, index and flags of every result and
// compares each output transfer with the oldest prediction. Both stream
// sides stall at random, apart from one stretch that runs at full rate.
// ============================================================================

module int8_concat_requantizer_tb;

    localparam int CLOCK_HALF     = 6;
    localparam int RESET_CYCLES   = 11;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int SAMPLE_TARGET  = 1850;
    localparam int IDLE_PERCENT   = 35;
    localparam int CALM_START     = 700;
    localparam int CALM_END       = 1000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int RATIO_FRAC     = 16;
    localparam int CFG_DATA_WIDTH = 24;

    // Index that maps to no register; writes to it must change nothing.
    localparam logic [i8cr_pkg::CFG_INDEX_WIDTH-1:0] CFG_UNUSED = 3'd7;

    typedef struct packed {
        logic [i8cr_pkg::SAMPLE_WIDTH-1:0] value;
        logic [i8cr_pkg::INDEX_WIDTH-1:0]  index;
        logic                              second;
        logic                              last;
    } t_result;

    // Predicts each result from its sample and checks the output transfers.
    class t_requant_scoreboard;
        logic [i8cr_pkg::RATIO_WIDTH-1:0]  first_ratio;
        logic [i8cr_pkg::RATIO_WIDTH-1:0]  second_ratio;
        logic [i8cr_pkg::SAMPLE_WIDTH-1:0] clamp_low;
        logic [i8cr_pkg::SAMPLE_WIDTH-1:0] clamp_high;
        logic [23:0]                       first_length;
        logic [23:0]                       second_length;
        logic [i8cr_pkg::BATCH_WIDTH-1:0]  batch_count;
        logic                              in_second;
        logic [23:0]                       position;
        logic [i8cr_pkg::BATCH_WIDTH-1:0]  batch_pos;
        logic [i8cr_pkg::INDEX_WIDTH-1:0]  next_index;
        t_result                           expected_q[$];
        int                                errors;

        function new();
            first_ratio   = i8cr_pkg::RATIO_RESET;
            second_ratio  = i8cr_pkg::RATIO_RESET;
            clamp_low     = i8cr_pkg::CLAMP_LOW_RESET;
            clamp_high    = i8cr_pkg::CLAMP_HIGH_RESET;
            first_length  = 24'd1;
            second_length = 24'd1;
            batch_count   = i8cr_pkg::BATCH_RESET;
            in_second     = 1'b0;
            position      = '0;
            batch_pos     = '0;
            next_index    = '0;
            errors        = 0;
        endfunction

        function void write_reg(logic [i8cr_pkg::CFG_INDEX_WIDTH-1:0] index,
                                logic [CFG_DATA_WIDTH-1:0] data);
            case (index)
                i8cr_pkg::CFG_FIRST_RATIO:   first_ratio   = data;
                i8cr_pkg::CFG_SECOND_RATIO:  second_ratio  = data;
                i8cr_pkg::CFG_CLAMP_LOW:     clamp_low     = data[7:0];
                i8cr_pkg::CFG_CLAMP_HIGH:    clamp_high    = data[7:0];
                i8cr_pkg::CFG_FIRST_LENGTH:  first_length  = data;
                i8cr_pkg::CFG_SECOND_LENGTH: second_length = data;
                i8cr_pkg::CFG_BATCH_COUNT:   batch_count   = data[7:0];
                default: ;
            endcase
        endfunction

        function void note_sample(logic [i8cr_pkg::SAMPLE_WIDTH-1:0] raw);
            longint          sample;
            longint          level;
            longint          lo;
            longint          hi;
            longint unsigned magnitude;
            longint unsigned product;
            longint unsigned rounded;
            logic [23:0]     ratio;
            logic [23:0]     limit;
            logic            seg_end;
            logic            batch_end;
            t_result         want;

            // Scale the magnitude, round half away from zero, restore the sign.
            sample    = longint'($signed(raw));
            ratio     = in_second ? second_ratio : first_ratio;
            magnitude = (sample < 0) ? -sample : sample;
            product   = magnitude * ratio;
            rounded   = (product + (64'd1 << (RATIO_FRAC - 1))) >> RATIO_FRAC;
            level     = (sample < 0) ? -longint'(rounded) : longint'(rounded);

            // Raise to the low limit first, then cap at the high limit.
            lo = longint'($signed(clamp_low));
            hi = longint'($signed(clamp_high));
            if (level < lo) level = lo;
            if (level > hi) level = hi;

            // A zero length or batch count ends at once, as if it were one.
            limit     = in_second ? second_length : first_length;
            seg_end   = ({1'b0, position} + 25'd1) >= {1'b0, limit};
            batch_end = ({1'b0, batch_pos} + 9'd1) >= {1'b0, batch_count};

            want.value  = level[7:0];
            want.index  = next_index;
            want.second = in_second;
            want.last   = in_second && seg_end && batch_end;
            expected_q.push_back(want);

            // Advance the segment, position, batch and index counters.
            if (want.last) begin
                in_second  = 1'b0;
                position   = '0;
                batch_pos  = '0;
                next_index = '0;
            end else begin
                next_index = next_index + 33'd1;
                if (seg_end) begin
                    position = '0;
                    if (in_second) begin
                        in_second = 1'b0;
                        batch_pos = batch_pos + 8'd1;
                    end else begin
                        in_second = 1'b1;
                    end
                end else begin
                    position = position + 24'd1;
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(string what, logic [47:0] got, logic [47:0] want);
            errors++;
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h",
                     $time, what, got, want);
        endtask

        task check_result(logic [i8cr_pkg::SAMPLE_WIDTH-1:0] value,
                          logic [i8cr_pkg::INDEX_WIDTH-1:0] index,
                          logic second, logic last);
            t_result want;
            if (expected_q.size() == 0) begin
                report("result with nothing pending", 48'({index, value}), '0);
                return;
            end
            want = expected_q.pop_front();
            if (value !== want.value)   report("out_value", 48'(value), 48'(want.value));
            if (index !== want.index)   report("out_index", 48'(index), 48'(want.index));
            if (second !== want.second) report("from_second", 48'(second), 48'(want.second));
            if (last !== want.last)     report("is_last", 48'(last), 48'(want.last));
        endtask
    endclass

    bit                                          i_clk;
    logic                                        i_rst_n;
    logic                                        i_cfg_wr_en;
    logic [i8cr_pkg::CFG_INDEX_WIDTH-1:0]        i_cfg_index;
    logic [CFG_DATA_WIDTH-1:0]                   i_cfg_data;
    logic                                        s_axis_tvalid;
    logic                                        s_axis_tready;
    logic [i8cr_pkg::IN_TDATA_WIDTH-1:0]         s_axis_tdata;   // [7:0] sample_value
    logic                                        m_axis_tvalid;
    logic                                        m_axis_tready;
    // [7:0] out_value, [40:8] out_index
    logic [i8cr_pkg::OUT_TDATA_WIDTH-1:0]        m_axis_tdata;
    logic                                        m_axis_tuser;   // [0] from_second
    logic                                        m_axis_tlast;   // is_last

    t_requant_scoreboard sb;
    bit                  in_fire;
    bit                  idle_on;
    int                  sent_count;
    int                  cycle_count;

    int8_concat_requantizer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #CLOCK_HALF i_clk = 1'b1;
        #CLOCK_HALF i_clk = 1'b0;
    end

    // Sample both streams at the rising edge; the sender reads in_fire later.
    always @(posedge i_clk) begin
        in_fire = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (in_fire) sb.note_sample(s_axis_tdata);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata[7:0], m_axis_tdata[40:8], m_axis_tuser, m_axis_tlast);
        end
    end

    // The receiver stalls at random outside the full-rate stretch.
    always @(negedge i_clk) begin
        m_axis_tready <= !idle_on || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Give up if the run hangs.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("CHECKS FAILED");
        $finish;
    end

    // Offer one sample, with a random gap first, and hold it until its transfer.
    task automatic send_sample(input logic [i8cr_pkg::SAMPLE_WIDTH-1:0] value);
        while (idle_on && ($urandom_range(0, 99) < IDLE_PERCENT)) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        sent_count++;
        @(negedge i_clk);
        while (!in_fire) @(negedge i_clk);
    endtask

    // One register write; the enable stays high for the caller to lower.
    task automatic put_reg(input logic [i8cr_pkg::CFG_INDEX_WIDTH-1:0] index,
                           input logic [CFG_DATA_WIDTH-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        sb.write_reg(index, data);
        @(negedge i_clk);
    endtask

    task automatic load_config(input logic [CFG_DATA_WIDTH-1:0] first_ratio,
                               input logic [CFG_DATA_WIDTH-1:0] second_ratio,
                               input logic [CFG_DATA_WIDTH-1:0] clamp_low,
                               input logic [CFG_DATA_WIDTH-1:0] clamp_high,
                               input logic [CFG_DATA_WIDTH-1:0] first_length,
                               input logic [CFG_DATA_WIDTH-1:0] second_length,
                               input logic [CFG_DATA_WIDTH-1:0] batch_count);
        put_reg(i8cr_pkg::CFG_FIRST_RATIO, first_ratio);
        put_reg(i8cr_pkg::CFG_SECOND_RATIO, second_ratio);
        put_reg(i8cr_pkg::CFG_CLAMP_LOW, clamp_low);
        put_reg(i8cr_pkg::CFG_CLAMP_HIGH, clamp_high);
        put_reg(i8cr_pkg::CFG_FIRST_LENGTH, first_length);
        put_reg(i8cr_pkg::CFG_SECOND_LENGTH, second_length);
        put_reg(i8cr_pkg::CFG_BATCH_COUNT, batch_count);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Stop offering samples and let the pipeline empty.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [CFG_DATA_WIDTH-1:0] pick_ratio();
        logic [CFG_DATA_WIDTH-1:0] ratio;
        ratio = CFG_DATA_WIDTH'($urandom);
        case ($urandom_range(0, 5))
            0:       ratio = '0;
            1:       ratio = 24'hFF_FFFF;
            2:       ;
            default: ratio = CFG_DATA_WIDTH'($urandom_range(24'h00_2000, 24'h03_0000));
        endcase
        return ratio;
    endfunction

    // Mostly short segments, now and then zero or an unreachable length.
    function automatic logic [CFG_DATA_WIDTH-1:0] pick_length();
        logic [CFG_DATA_WIDTH-1:0] length;
        length = CFG_DATA_WIDTH'($urandom);
        case ($urandom_range(0, 9))
            0:       length = '0;
            1:       ;
            2, 3:    length = CFG_DATA_WIDTH'($urandom_range(7, 40));
            default: length = CFG_DATA_WIDTH'($urandom_range(1, 6));
        endcase
        return length;
    endfunction

    initial begin
        logic [CFG_DATA_WIDTH-1:0]         low;
        logic [CFG_DATA_WIDTH-1:0]         high;
        logic [CFG_DATA_WIDTH-1:0]         batches;
        logic [i8cr_pkg::SAMPLE_WIDTH-1:0] sample;
        int                                burst;

        sb            = new();
        idle_on       = 1'b1;
        sent_count    = 0;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_index   = i8cr_pkg::CFG_FIRST_RATIO;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: unit ratios, full range, one sample per segment.
        send_sample(8'h80);
        send_sample(8'h7F);
        send_sample(8'h00);
        send_sample(8'hFF);
        wait_idle();

        // Largest and zero ratio, two batches of two plus one samples.
        load_config(24'hFF_FFFF, 24'h00_0000, 24'h00_0080, 24'h00_007F,
                    24'd2, 24'd1, 24'd2);
        send_sample(8'h7F);
        send_sample(8'h80);
        send_sample(8'd100);
        send_sample(8'h01);
        send_sample(8'hFF);
        send_sample(8'h80);
        wait_idle();

        // Rounding ties at one half and three halves, narrow clamp window.
        load_config(24'h00_8000, 24'h01_8000, 24'h00_00FB, 24'h00_0005,
                    24'd4, 24'd2, 24'd1);
        send_sample(8'h01);
        send_sample(8'hFF);
        send_sample(8'h03);
        send_sample(8'hFD);
        send_sample(8'h07);
        send_sample(8'hF9);
        wait_idle();

        // Inverted clamp limits and zero lengths and batch count; a write to
        // the unused index must leave every register alone.
        put_reg(CFG_UNUSED, 24'hFF_FFFF);
        load_config(24'h01_0000, 24'h01_0000, 24'h00_000A, 24'h00_00F6,
                    24'd0, 24'd0, 24'd0);
        send_sample(8'h00);
        send_sample(8'h7F);
        send_sample(8'h80);
        send_sample(8'd50);
        wait_idle();

        // Largest lengths and batch count, then shrink the first segment while
        // the position is already past the new length.
        load_config(24'h01_0000, 24'h01_0000, 24'h00_0080, 24'h00_007F,
                    24'hFF_FFFF, 24'hFF_FFFF, 24'h00_00FF);
        send_sample(8'd10);
        send_sample(8'd20);
        send_sample(8'd30);
        wait_idle();
        load_config(24'h01_0000, 24'h01_0000, 24'h00_0080, 24'h00_007F,
                    24'd1, 24'd2, 24'd1);
        send_sample(8'd40);
        send_sample(8'd50);
        send_sample(8'd60);
        wait_idle();

        // Random settings, each followed by a burst that may stop mid-tensor.
        while (sent_count < SAMPLE_TARGET) begin
            low     = CFG_DATA_WIDTH'($urandom);
            high    = CFG_DATA_WIDTH'($urandom);
            batches = CFG_DATA_WIDTH'($urandom);
            case ($urandom_range(0, 5))
                0: begin
                    low[7:0]  = 8'h80;
                    high[7:0] = 8'h7F;
                end
                1: ;
                default: begin
                    low[7:0]  = 8'h80 + 8'($urandom_range(0, 128));
                    high[7:0] = 8'($urandom_range(0, 127));
                end
            endcase
            case ($urandom_range(0, 7))
                0:       batches[7:0] = 8'h00;
                1:       batches[7:0] = 8'hFF;
                2:       ;
                default: batches[7:0] = 8'($urandom_range(1, 3));
            endcase
            load_config(pick_ratio(), pick_ratio(), low, high,
                        pick_length(), pick_length(), batches);

            burst = $urandom_range(10, 70);
            repeat (burst) begin
                sample = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 7) == 0) begin
                    case ($urandom_range(0, 3))
                        0:       sample = 8'h80;
                        1:       sample = 8'h7F;
                        2:       sample = 8'h00;
                        default: sample = 8'hFF;
                    endcase
                end
                idle_on = !(sent_count >= CALM_START && sent_count < CALM_END);
                send_sample(sample);
            end
            wait_idle();
        end

        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
